// File: rtl/core/fus_pkg.sv
`default_nettype none

package fus_pkg;

    // Result kinds
    localparam logic [2:0] KIND_USER = 3'd0;
    localparam logic [2:0] KIND_PASS = 3'd1;
    localparam logic [2:0] KIND_HOST = 3'd2;
    localparam logic [2:0] KIND_PATH = 3'd3;
    localparam logic [2:0] KIND_FILE = 3'd4;
    localparam logic [2:0] KIND_ANON = 3'd5;
    localparam logic [2:0] KIND_PERR = 3'd6;
    localparam logic [2:0] KIND_DONE = 3'd7;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;

    // Position of the last character of the scheme text
    localparam logic [2:0] PREFIX_LAST = 3'd5;

    // Scheme text "ftp://"
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h66;
            3'd1:    ch = 8'h74;
            3'd2:    ch = 8'h70;
            3'd3:    ch = CH_COLON;
            3'd4:    ch = CH_SLASH;
            3'd5:    ch = CH_SLASH;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_TEXT,
        SRC_HOLD
    } out_src_t;

    typedef struct packed {
        logic       hold_wr;
        logic       hold_clr;
        logic       ovf_clr;
        logic       pfx_adv;
        logic       pfx_clr;
        logic       flush_start;
        logic       flush_adv;
        logic       out_load;
        logic [2:0] out_kind;
        out_src_t   out_src;
        logic       out_run_end;
    } fus_cmd_t;

    typedef struct packed {
        logic can_load;
        logic prefix_hit;
        logic prefix_final;
        logic is_slash;
        logic is_colon;
        logic is_at;
        logic hold_empty;
        logic flush_last;
    } fus_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/fus_ifs.sv
`default_nettype none

interface fus_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_url;

    modport source (output valid, output char_code, output end_of_url, input ready);
    modport sink   (input valid, input char_code, input end_of_url, output ready);
endinterface

interface fus_field_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_value;
    logic       overflowed;
    logic       run_end;

    modport source (output valid, output kind, output char_value, output overflowed,
                    output run_end, input ready);
    modport sink   (input valid, input kind, input char_value, input overflowed,
                    input run_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fus_dp.sv
`default_nettype none

module fus_dp #(
    parameter int BUF_DEPTH = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      char_code,
    input  wire fus_pkg::fus_cmd_t  cmd,
    output fus_pkg::fus_stat_t   stat,
    fus_field_if.source          field
);
    import fus_pkg::*;

    localparam int CNT_W = $clog2(BUF_DEPTH + 1);
    localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);

    logic [7:0]       hold_mem [BUF_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] idx_inc;
    logic             ovf_reg, ovf_next;
    logic [2:0]       pfx_reg, pfx_next;
    logic             hold_full;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    logic       out_valid_reg;
    logic [2:0] out_kind_reg;
    logic [7:0] out_char_reg;
    logic       out_ovf_reg;
    logic       out_run_end_reg;
    logic [7:0] load_char;

    assign hold_full = (count_reg == DEPTH_C);
    assign wr_addr   = count_reg[IDX_W-1:0];
    assign idx_inc   = idx_reg + CNT_W'(1);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.flush_start)
        begin
            idx_next = '0;
        end
        else if (cmd.flush_adv)
        begin
            idx_next = idx_inc;
        end
        rd_addr = (idx_next < DEPTH_C) ? idx_next[IDX_W-1:0] : '0;
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pfx_next   = pfx_reg;
        if (cmd.hold_clr)
        begin
            count_next = '0;
        end
        else if (cmd.hold_wr)
        begin
            if (hold_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.ovf_clr)
        begin
            ovf_next = 1'b0;
        end
        if (cmd.pfx_clr)
        begin
            pfx_next = '0;
        end
        else if (cmd.pfx_adv)
        begin
            pfx_next = pfx_reg + 3'd1;
        end
    end

    always_comb
    begin
        case (cmd.out_src)
            SRC_TEXT: load_char = char_code;
            SRC_HOLD: load_char = rd_data_reg;
            default:  load_char = 8'h00;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_wr && !hold_full)
        begin
            hold_mem[wr_addr] <= char_code;
        end
        rd_data_reg <= hold_mem[rd_addr];
        if (cmd.out_load)
        begin
            out_kind_reg    <= cmd.out_kind;
            out_char_reg    <= load_char;
            out_ovf_reg     <= ovf_reg;
            out_run_end_reg <= cmd.out_run_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            ovf_reg       <= 1'b0;
            pfx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
            pfx_reg   <= pfx_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (field.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.can_load     = !out_valid_reg || field.ready;
    assign stat.prefix_hit   = (char_code == prefix_char(pfx_reg));
    assign stat.prefix_final = (pfx_reg == PREFIX_LAST);
    assign stat.is_slash     = (char_code == CH_SLASH);
    assign stat.is_colon     = (char_code == CH_COLON);
    assign stat.is_at        = (char_code == CH_AT);
    assign stat.hold_empty   = (count_reg == '0);
    assign stat.flush_last   = (idx_inc == count_reg);

    assign field.valid      = out_valid_reg;
    assign field.kind       = out_kind_reg;
    assign field.char_value = out_char_reg;
    assign field.overflowed = out_ovf_reg;
    assign field.run_end    = out_run_end_reg;

endmodule

`default_nettype wire

// File: rtl/core/fus_ctrl.sv
`default_nettype none

module fus_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               text_valid,
    input  wire logic               end_of_url,
    output logic                    text_ready,
    input  wire fus_pkg::fus_stat_t stat,
    output fus_pkg::fus_cmd_t       cmd
);
    import fus_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_FLUSH,
        ST_ANON,
        ST_FINAL,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_USER,
        PH_PASS,
        PH_HOST,
        PH_PATH,
        PH_ERROR
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       last_reg, last_next;
    logic [2:0] fkind_reg, fkind_next;
    logic       anon_reg, anon_next;
    logic       final_reg, final_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        fkind_next = fkind_reg;
        anon_next  = anon_reg;
        final_next = final_reg;
        cmd        = '0;
        cmd.out_src = SRC_ZERO;
        text_ready = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                text_ready = stat.can_load;
                if (text_valid && stat.can_load)
                begin
                    last_next  = end_of_url;
                    state_next = end_of_url ? ST_FINAL : ST_IDLE;
                    case (phase_reg)
                        PH_PREFIX:
                        begin
                            if (stat.prefix_hit)
                            begin
                                cmd.pfx_adv = 1'b1;
                                if (stat.prefix_final)
                                begin
                                    phase_next = PH_USER;
                                end
                            end
                            else
                            begin
                                cmd.out_load    = 1'b1;
                                cmd.out_kind    = KIND_PERR;
                                cmd.out_run_end = !end_of_url;
                                phase_next      = PH_ERROR;
                            end
                        end
                        PH_USER:
                        begin
                            if (stat.is_slash)
                            begin
                                // held text turns out to be the host
                                phase_next = PH_PATH;
                                fkind_next = KIND_HOST;
                                anon_next  = 1'b1;
                                final_next = 1'b0;
                                state_next = stat.hold_empty ? ST_ANON : ST_PREP;
                            end
                            else if (stat.is_colon)
                            begin
                                phase_next = PH_PASS;
                                fkind_next = KIND_USER;
                                anon_next  = 1'b0;
                                final_next = 1'b0;
                                if (!stat.hold_empty)
                                begin
                                    state_next = ST_PREP;
                                end
                            end
                            else
                            begin
                                cmd.hold_wr = 1'b1;
                            end
                        end
                        PH_PASS:
                        begin
                            if (stat.is_at)
                            begin
                                phase_next = PH_HOST;
                            end
                            else
                            begin
                                cmd.out_load    = 1'b1;
                                cmd.out_kind    = KIND_PASS;
                                cmd.out_src     = SRC_TEXT;
                                cmd.out_run_end = !end_of_url;
                            end
                        end
                        PH_HOST:
                        begin
                            if (stat.is_slash)
                            begin
                                phase_next = PH_PATH;
                            end
                            else
                            begin
                                cmd.out_load    = 1'b1;
                                cmd.out_kind    = KIND_HOST;
                                cmd.out_src     = SRC_TEXT;
                                cmd.out_run_end = !end_of_url;
                            end
                        end
                        PH_PATH:
                        begin
                            cmd.out_load    = 1'b1;
                            cmd.out_kind    = KIND_PATH;
                            cmd.out_src     = SRC_TEXT;
                            cmd.out_run_end = !end_of_url;
                            // a slash restarts the filename segment
                            if (stat.is_slash)
                            begin
                                cmd.hold_clr = 1'b1;
                            end
                            else
                            begin
                                cmd.hold_wr = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PREP:
            begin
                // prime the buffer read for entry zero
                cmd.flush_start = 1'b1;
                state_next      = ST_FLUSH;
            end

            ST_FLUSH:
            begin
                if (stat.can_load)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = fkind_reg;
                    cmd.out_src   = SRC_HOLD;
                    cmd.flush_adv = 1'b1;
                    if (stat.flush_last)
                    begin
                        cmd.hold_clr    = 1'b1;
                        cmd.out_run_end = !anon_reg && !last_reg;
                        if (anon_reg)
                        begin
                            state_next = ST_ANON;
                        end
                        else if (final_reg)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = last_reg ? ST_FINAL : ST_IDLE;
                        end
                    end
                end
            end

            ST_ANON:
            begin
                if (stat.can_load)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_kind    = KIND_ANON;
                    cmd.out_run_end = !last_reg;
                    anon_next       = 1'b0;
                    state_next      = last_reg ? ST_FINAL : ST_IDLE;
                end
            end

            ST_FINAL:
            begin
                if ((phase_reg inside {PH_USER, PH_PATH}) && !stat.hold_empty)
                begin
                    fkind_next = (phase_reg == PH_USER) ? KIND_USER : KIND_FILE;
                    anon_next  = 1'b0;
                    final_next = 1'b1;
                    state_next = ST_PREP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (stat.can_load)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_kind    = KIND_DONE;
                    cmd.out_run_end = 1'b1;
                    cmd.hold_clr    = 1'b1;
                    cmd.ovf_clr     = 1'b1;
                    cmd.pfx_clr     = 1'b1;
                    phase_next      = PH_PREFIX;
                    last_next       = 1'b0;
                    final_next      = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_PREFIX;
            last_reg  <= 1'b0;
            fkind_reg <= KIND_USER;
            anon_reg  <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
            fkind_reg <= fkind_next;
            anon_reg  <= anon_next;
            final_reg <= final_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ftp_url_field_splitter.sv
// Splits an ftp URL, fed one byte per transfer on the text channel, into
// tagged bytes on the field channel (user, password, host, path, filename,
// anonymous marker, prefix error, done). end_of_url marks the last byte;
// every URL closes with a done result, and run_end flags the last result
// caused by each input byte.
// A byte that yields a result shows it on the field channel in the cycle
// after its transfer. Plain bytes go at one per cycle while results are taken.
// A flush of held bytes (user bytes resolved by ':' or '/', or the user or
// filename bytes at end of URL) stalls the text channel through ST_PREP and
// ST_FLUSH, one buffer read per cycle while results are taken; the anonymous
// marker and done have their own states; ST_FINAL picks the final flush.
// Bytes beyond BUF_DEPTH in a held segment are dropped and overflowed is set
// until the URL ends.
// The field channel has an output register: when the receiver stalls, the
// result holds and the text channel is held off until it is taken.
// Reset returns the block to the prefix check with empty hold buffer; the
// buffer needs no clearing pass.
`default_nettype none

module ftp_url_field_splitter #(
    parameter int BUF_DEPTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fus_text_if.sink    text,
    fus_field_if.source field
);
    import fus_pkg::*;

    fus_cmd_t  cmd;
    fus_stat_t stat;
    logic      ready_w;

    assign text.ready = ready_w;

    fus_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text.valid),
        .end_of_url (text.end_of_url),
        .text_ready (ready_w),
        .stat       (stat),
        .cmd        (cmd)
    );

    fus_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (text.char_code),
        .cmd       (cmd),
        .stat      (stat),
        .field     (field)
    );

endmodule

`default_nettype wire

// File: rtl/core/fus_checker.sv
`default_nettype none

module fus_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       text_valid,
    input wire logic       text_ready,
    input wire logic       field_valid,
    input wire logic       field_ready,
    input wire logic [2:0] field_kind,
    input wire logic [7:0] field_char_value,
    input wire logic       field_overflowed,
    input wire logic       field_run_end
);
    import fus_pkg::*;

    // Hold a stalled result unchanged
    a_field_hold: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && !field_ready |=> field_valid &&
        $stable({field_kind, field_char_value, field_overflowed, field_run_end}))
        else $error("field result changed while stalled");

    // Done always closes the run of its byte
    a_done_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && field_kind == KIND_DONE |-> field_run_end)
        else $error("done result without run_end");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && (field_kind == KIND_ANON || field_kind == KIND_PERR ||
        field_kind == KIND_DONE) |-> field_char_value == 8'h00)
        else $error("marker result carries a character");

    // Accept text only when the output slot can take a result
    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready |-> !field_valid || field_ready)
        else $error("text transfer while field slot is blocked");

endmodule

bind ftp_url_field_splitter fus_checker u_fus_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .text_valid       (text.valid),
    .text_ready       (text.ready),
    .field_valid      (field.valid),
    .field_ready      (field.ready),
    .field_kind       (field.kind),
    .field_char_value (field.char_value),
    .field_overflowed (field.overflowed),
    .field_run_end    (field.run_end)
);

`default_nettype wire
